### hw/rtl/fdccp_pkg.sv
// shared types, codes and tables for the floppy controller command phases
`default_nettype none

package fdccp_pkg;

  // default drive count
  localparam int DRIVES_DEFAULT = 4;

  // field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int DMALEN_W = 20;
  localparam int MASK_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // command byte buffer and result buffer depths
  localparam int CMD_BYTES = 9;
  localparam int RES_BYTES = 7;

  // bus access kinds
  typedef enum logic [CMD_W-1:0] {
    OP_STATUS = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RESULT = 2'd2
  } bus_op_t;

  // configuration register indexes
  localparam logic CFG_READY_MASK = 1'b0;
  localparam logic CFG_DMA_LEN    = 1'b1;

  // opcodes, low nibble of the first command byte
  localparam logic [3:0] OPC_SPECIFY    = 4'h3;
  localparam logic [3:0] OPC_WRITE_DATA = 4'h5;
  localparam logic [3:0] OPC_READ_DATA  = 4'h6;
  localparam logic [3:0] OPC_RECAL      = 4'h7;
  localparam logic [3:0] OPC_SENSE_INT  = 4'h8;
  localparam logic [3:0] OPC_WRITE_ID   = 4'hd;
  localparam logic [3:0] OPC_SEEK       = 4'hf;

  // status and result byte constants
  localparam logic [7:0] ST_RQM      = 8'h80;
  localparam logic [7:0] ST_DIO      = 8'h40;
  localparam logic [7:0] ST_BUSY     = 8'h10;
  localparam logic [7:0] ST0_WP      = 8'h40;
  localparam logic [7:0] ST0_SEEKEND = 8'h20;
  localparam logic [7:0] ST0_INVALID = 8'ha0;
  localparam logic [7:0] ST1_NOT_WR  = 8'h02;
  localparam logic [7:0] NO_RESULT   = 8'h80;
  localparam logic [7:0] BAD_CYL     = 8'hff;

  // largest sector size code
  localparam logic [2:0] SIZE_CODE_MAX = 3'd5;
  // sector size of code zero is 1 << SIZE_SHIFT_BASE
  localparam logic [3:0] SIZE_SHIFT_BASE = 4'd7;

  // one bus beat handed to the core
  typedef struct packed {
    logic            en;
    bus_op_t         cmd;
    logic [BYTE_W-1:0] wdata;
  } bus_beat_t;

  // command length per opcode
  function automatic logic [3:0] cmd_len(input logic [3:0] opc);
    logic [3:0] len;
    case (opc)
      4'h0:    len = 4'd1;
      4'h1:    len = 4'd9;
      4'h2:    len = 4'd9;
      4'h3:    len = 4'd3;
      4'h4:    len = 4'd2;
      4'h5:    len = 4'd9;
      4'h6:    len = 4'd9;
      4'h7:    len = 4'd2;
      4'h8:    len = 4'd1;
      4'h9:    len = 4'd9;
      4'ha:    len = 4'd2;
      4'hb:    len = 4'd1;
      4'hc:    len = 4'd9;
      4'hd:    len = 4'd6;
      4'he:    len = 4'd1;
      default: len = 4'd3;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fdccp_core.sv
// controller state: command collection, execution and result readout
`default_nettype none

module fdccp_core import fdccp_pkg::*; #(
  parameter int DRIVES = DRIVES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [DMALEN_W-1:0] cfg_wdata,
  input  wire bus_beat_t           beat,
  output logic [BYTE_W-1:0]        rdata
);

  localparam int IDX_W = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam logic [2:0] DRV_LIMIT = 3'(DRIVES);

  typedef enum logic [1:0] {
    PH_CMD    = 2'd0,
    PH_BUSY   = 2'd1,
    PH_RESULT = 2'd2
  } phase_t;

  // architectural state
  logic [MASK_W-1:0]   ready_mask;
  logic [DMALEN_W-1:0] dma_len;
  logic [BYTE_W-1:0]   cbytes [CMD_BYTES];
  logic [3:0]          wpos;
  logic [BYTE_W-1:0]   rbytes [RES_BYTES];
  logic [2:0]          rpos;
  logic [2:0]          rcount;
  phase_t              phase;
  logic                dma_mode;
  logic [1:0]          sel_drive;
  logic [BYTE_W-1:0]   cyl [DRIVES];

  // next values
  logic [3:0]        wpos_next;
  logic [BYTE_W-1:0] rbytes_next [RES_BYTES];
  logic [2:0]        rpos_next;
  logic [2:0]        rcount_next;
  phase_t            phase_next;
  logic              dma_mode_next;
  logic [1:0]        sel_drive_next;
  logic              cyl_we;
  logic [IDX_W-1:0]  cyl_idx;
  logic [BYTE_W-1:0] cyl_val;
  logic              cb_we;

  // helpers
  logic [3:0]          wp_eff;
  logic [3:0]          wp_inc;
  logic [BYTE_W-1:0]   view [CMD_BYTES];
  logic [1:0]          drv;
  logic                drv_ok;
  logic                sel_ready;
  logic [2:0]          size_code;
  logic [3:0]          size_sh;
  logic [DMALEN_W:0]   len_round;
  logic [DMALEN_W:0]   k_full;
  logic [14:0]         k_sect;
  logic [BYTE_W-1:0]   span;
  logic [BYTE_W-1:0]   advance;
  logic [BYTE_W-1:0]   last_sector;
  logic [2:0]          rpos_inc;

  // command byte view with the incoming byte in place
  always_comb begin
    wp_eff = (wpos > 4'd8) ? 4'd0 : wpos;
    wp_inc = wp_eff + 4'd1;
    for (int i = 0; i < CMD_BYTES; i++) begin
      view[i] = (wp_eff == 4'(i)) ? beat.wdata : cbytes[i];
    end
  end

  // drive decode
  always_comb begin
    drv       = view[1][1:0];
    drv_ok    = ({1'b0, drv} < DRV_LIMIT);
    sel_ready = ({1'b0, sel_drive} < DRV_LIMIT) && ready_mask[sel_drive];
  end

  // read data end sector: sectors in the dma buffer, capped by end of track
  always_comb begin
    size_code = (view[5] > 8'(SIZE_CODE_MAX)) ? SIZE_CODE_MAX : view[5][2:0];
    size_sh   = SIZE_SHIFT_BASE + {1'b0, size_code};
    len_round = {1'b0, dma_len} + (((DMALEN_W+1)'(1) << size_sh) - (DMALEN_W+1)'(1));
    k_full    = len_round >> size_sh;
    k_sect    = (k_full[14:0] == 15'd0) ? 15'd1 : k_full[14:0];
    span      = view[6] - view[4];
    advance   = ({7'd0, span} < k_sect) ? span : k_sect[7:0];
    last_sector = view[4] + advance;
  end

  // step logic for one bus beat
  always_comb begin
    wpos_next      = wpos;
    rpos_next      = rpos;
    rcount_next    = rcount;
    phase_next     = phase;
    dma_mode_next  = dma_mode;
    sel_drive_next = sel_drive;
    for (int i = 0; i < RES_BYTES; i++) begin
      rbytes_next[i] = rbytes[i];
    end
    cyl_we   = 1'b0;
    cyl_idx  = drv[IDX_W-1:0];
    cyl_val  = '0;
    cb_we    = 1'b0;
    rdata    = '0;
    rpos_inc = rpos + 3'd1;

    case (beat.cmd)
      OP_STATUS: begin
        rdata = ST_RQM;
        if (wpos != 4'd0 || rpos != 3'd0) begin
          rdata = rdata | ST_BUSY;
        end
        if (phase == PH_RESULT) begin
          rdata = rdata | ST_DIO;
        end
      end

      OP_WRITE: begin
        cb_we = 1'b1;
        if (cmd_len(view[0][3:0]) <= wp_inc) begin
          wpos_next = '0;
          // execute
          case (view[0][3:0])
            OPC_SPECIFY: begin
              dma_mode_next = ~view[2][0];
              phase_next    = PH_CMD;
            end
            OPC_WRITE_DATA: begin
              if (dma_mode) begin
                rbytes_next[0] = ST0_WP | {6'd0, sel_drive};
                rbytes_next[1] = ST1_NOT_WR;
                rbytes_next[2] = '0;
                rbytes_next[3] = view[2];
                rbytes_next[4] = view[3];
                rbytes_next[5] = view[4];
                rbytes_next[6] = view[5];
                rcount_next    = 3'(RES_BYTES);
                rpos_next      = '0;
                phase_next     = PH_RESULT;
              end
            end
            OPC_READ_DATA: begin
              if (dma_mode) begin
                rbytes_next[0] = {6'd0, sel_drive};
                rbytes_next[1] = '0;
                rbytes_next[2] = '0;
                rbytes_next[3] = view[2];
                rbytes_next[4] = view[3];
                rbytes_next[5] = last_sector;
                rbytes_next[6] = view[5];
                rcount_next    = 3'(RES_BYTES);
                rpos_next      = '0;
                phase_next     = PH_RESULT;
              end
            end
            OPC_RECAL: begin
              sel_drive_next = drv;
              cyl_we         = drv_ok;
              cyl_val        = '0;
              phase_next     = PH_CMD;
            end
            OPC_SENSE_INT: begin
              if (sel_ready) begin
                rbytes_next[0] = ST0_SEEKEND | {6'd0, sel_drive};
                rbytes_next[1] = cyl[sel_drive[IDX_W-1:0]];
              end else begin
                rbytes_next[0] = ST0_INVALID | {6'd0, sel_drive};
                rbytes_next[1] = BAD_CYL;
              end
              rcount_next = 3'd2;
              rpos_next   = '0;
              phase_next  = PH_RESULT;
            end
            OPC_WRITE_ID: begin
              rbytes_next[0] = ST0_WP | {6'd0, sel_drive};
              rbytes_next[1] = ST1_NOT_WR;
              rbytes_next[2] = '0;
              rcount_next    = 3'(RES_BYTES);
              rpos_next      = '0;
              phase_next     = PH_RESULT;
            end
            OPC_SEEK: begin
              sel_drive_next = drv;
              cyl_we         = drv_ok;
              cyl_val        = view[2];
              phase_next     = PH_CMD;
            end
            default: begin
              phase_next     = PH_CMD;
              rcount_next    = '0;
              rbytes_next[0] = NO_RESULT;
            end
          endcase
        end else begin
          wpos_next  = wp_inc;
          phase_next = PH_BUSY;
        end
      end

      OP_RESULT: begin
        rdata = NO_RESULT;
        if (phase == PH_RESULT) begin
          if (rcount > rpos && rpos < 3'(RES_BYTES)) begin
            rdata     = rbytes[rpos];
            rpos_next = rpos_inc;
          end
          if (rcount <= rpos_next) begin
            phase_next = PH_CMD;
            rpos_next  = '0;
          end
        end
      end

      default: begin
        rdata = '0;
      end
    endcase
  end

  // command byte buffer, undefined until written
  always_ff @(posedge clk) begin
    if (beat.en && cb_we) begin
      cbytes[wp_eff] <= beat.wdata;
    end
  end

  // control state, configuration, results and cylinders
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mask <= '0;
      dma_len    <= '0;
      wpos       <= '0;
      rpos       <= '0;
      rcount     <= '0;
      phase      <= PH_CMD;
      dma_mode   <= 1'b0;
      sel_drive  <= '0;
      for (int i = 0; i < RES_BYTES; i++) begin
        rbytes[i] <= '0;
      end
      for (int i = 0; i < DRIVES; i++) begin
        cyl[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_READY_MASK: ready_mask <= cfg_wdata[MASK_W-1:0];
          CFG_DMA_LEN:    dma_len    <= cfg_wdata;
          default:        ready_mask <= ready_mask;
        endcase
      end
      if (beat.en) begin
        wpos      <= wpos_next;
        rpos      <= rpos_next;
        rcount    <= rcount_next;
        phase     <= phase_next;
        dma_mode  <= dma_mode_next;
        sel_drive <= sel_drive_next;
        for (int i = 0; i < RES_BYTES; i++) begin
          rbytes[i] <= rbytes_next[i];
        end
        if (cyl_we) begin
          cyl[cyl_idx] <= cyl_val;
        end
      end
    end
  end

  // status reads leave the state alone
  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    beat.en && beat.cmd == OP_STATUS |=> $stable(phase) && $stable(wpos) && $stable(rpos))
    else $error("status read changed controller state");

  // the write pointer stays inside the command buffer after a write
  a_wpos_range: assert property (@(posedge clk) disable iff (rst)
    beat.en && beat.cmd == OP_WRITE |=> wpos <= 4'd8)
    else $error("command write pointer out of range");

  // result reads never move the read pointer outside the result phase
  a_rpos_phase: assert property (@(posedge clk) disable iff (rst)
    beat.en && beat.cmd == OP_RESULT && phase != PH_RESULT |=> $stable(rpos))
    else $error("result pointer moved outside result phase");

endmodule

`default_nettype wire

### hw/rtl/floppy_controller_command_phases.sv
// Floppy controller command/result phases, register side.
// A beat accepted into the input register updates the core state and loads the result register
// together, once the result register is empty or being read (m_tready).
// Throughput: one beat per cycle while the result side is not held back by m_tready low.
// Reset (rst, synchronous, active high): command phase, result buffer and pointers cleared,
// configuration registers zero, no result beat pending.
`default_nettype none

module floppy_controller_command_phases import fdccp_pkg::*; #(
  parameter int DRIVES = DRIVES_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input beats
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // cmd[1:0], wdata[9:2], zero pad
  // result beats
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // rdata[7:0]
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [DMALEN_W-1:0]    cfg_wdata
);

  // input register
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [BYTE_W-1:0] s1_wdata;
  logic              step;
  bus_beat_t         beat;
  logic [BYTE_W-1:0] core_rdata;

  assign step     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd   <= s_tdata[CMD_W-1:0];
      s1_wdata <= s_tdata[CMD_W+BYTE_W-1:CMD_W];
    end
  end

  // beat to the core
  always_comb begin
    beat.en    = step;
    beat.cmd   = bus_op_t'(s1_cmd);
    beat.wdata = s1_wdata;
  end

  fdccp_core #(
    .DRIVES(DRIVES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .beat     (beat),
    .rdata    (core_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= core_rdata;
    end
  end

  // input stalls only when both stages are full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // every processed beat shows up as a result beat
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed beat produced no result");

  // a held input beat is not lost while the output is blocked
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !step |=> s1_valid && $stable(s1_cmd) && $stable(s1_wdata))
    else $error("pending input beat lost");

endmodule

`default_nettype wire
